/* design/hrc_pkg.sv */
package hrc_pkg;

   // Field widths.
   localparam int HUE_W  = 13;
   localparam int BYTE_W = 8;

   // Hue format: HUE_FRAC_BITS fractional bits, in degrees.
   localparam int HUE_FRAC_BITS = 4;
   localparam int SECT_LEN      = 60 << HUE_FRAC_BITS;
   localparam int NUM_SECTORS   = 6;
   localparam int SECTOR_W      = 3;
   localparam int TRI_W         = $clog2(SECT_LEN + 1);

   // Chroma times 65025 and 510 times lightness.
   localparam int CHROMA_W = 16;
   localparam int LTERM_W  = 17;

   // Every channel is floor(N / DIVISOR), with N = SECT_LEN * A + 2 * chroma * w.
   localparam int DIVISOR = 510 * SECT_LEN;
   localparam longint unsigned NUM_MAX = 64'd260100 * SECT_LEN;
   localparam int NUM_W = $clog2(NUM_MAX);

   // Exact division by a reciprocal: floor(N * RECIP / 2^RECIP_SHIFT) for all N below 2^NUM_W.
   localparam int RECIP_SHIFT = NUM_W + $clog2(DIVISOR);
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int RECIP_W = NUM_W + 1;
   localparam int PROD_W  = NUM_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - RECIP_SHIFT;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_X,
      SEL_C
   } sel_type;

   typedef struct packed {
      sel_type red;
      sel_type green;
      sel_type blue;
   } chan_sel_type;

   // Places chroma and the second-largest component by hue sector.
   function automatic chan_sel_type sector_sel(input logic [SECTOR_W-1:0] sector);
      chan_sel_type sel;
      sel = '{red: SEL_ZERO, green: SEL_ZERO, blue: SEL_ZERO};
      unique case (sector)
         3'd0: begin sel.red = SEL_C; sel.green = SEL_X; end
         3'd1: begin sel.red = SEL_X; sel.green = SEL_C; end
         3'd2: begin sel.green = SEL_C; sel.blue = SEL_X; end
         3'd3: begin sel.green = SEL_X; sel.blue = SEL_C; end
         3'd4: begin sel.red = SEL_X; sel.blue = SEL_C; end
         3'd5: begin sel.red = SEL_C; sel.blue = SEL_X; end
         default: begin end
      endcase
      return sel;
   endfunction

endpackage

/* design/hsl_to_rgb_converter.sv */
// HSL to RGB pixel converter, five register stages deep.
// Throughput: one transaction per clock; each stage holds while the next one is full and blocked.
// The rate is set by the stage-four reciprocal multipliers, one per channel, fully pipelined.
// Reset (synchronous, active high) empties the pipeline; data registers are not cleared.
module hsl_to_rgb_converter import hrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [BYTE_W-1:0] req_saturation,
   input  logic [BYTE_W-1:0] req_lightness,
   input  logic [BYTE_W-1:0] req_alpha,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_red,
   output logic [BYTE_W-1:0] rsp_green,
   output logic [BYTE_W-1:0] rsp_blue,
   output logic [BYTE_W-1:0] rsp_opacity
);

   localparam int STAGES = 5;

   // Pipeline control. A stage loads when it is empty or when the stage after it moves,
   // so bubbles collapse and a stalled output holds the full stages up to the first empty one.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] advance;

   always_comb begin
      advance[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_in = valid_ff;
      if (advance[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (advance[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = advance[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Stage 1: chroma, hue sector and the triangle wave within the sector.
   // Chroma scaled by 65025 is (255 - |2L - 255|) * S. The triangle is the position within
   // the sector, mirrored on odd sectors. A hue past the last sector yields sector six (grey).
   logic [BYTE_W:0]        twol;
   logic [BYTE_W-1:0]      light_dist;
   logic [31:0]            hue_ext;
   logic [31:0]            base;
   logic [TRI_W-1:0]       pos;
   logic [CHROMA_W-1:0]    chroma_in, chroma_ff;
   logic [SECTOR_W-1:0]    sector_in, sector1_ff;
   logic [TRI_W-1:0]       tri_in, tri_ff;
   logic [BYTE_W-1:0]      light_ff;
   logic [BYTE_W-1:0]      alpha1_ff;

   always_comb begin
      twol = {req_lightness, 1'b0};
      if (twol >= 9'd255) begin
         light_dist = BYTE_W'(twol - 9'd255);
      end else begin
         light_dist = BYTE_W'(9'd255 - twol);
      end
      chroma_in = CHROMA_W'({8'd0, 8'd255 - light_dist} * {8'd0, req_saturation});

      hue_ext   = 32'(req_hue);
      base      = '0;
      sector_in = '0;
      for (int k = 1; k <= NUM_SECTORS; k++) begin
         if (hue_ext >= 32'(k * SECT_LEN)) begin
            base      = 32'(k * SECT_LEN);
            sector_in = SECTOR_W'(k);
         end
      end
      pos = TRI_W'(hue_ext - base);
      if (sector_in[0]) begin
         tri_in = TRI_W'(SECT_LEN) - pos;
      end else begin
         tri_in = pos;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         chroma_ff  <= chroma_in;
         sector1_ff <= sector_in;
         tri_ff     <= tri_in;
         light_ff   <= req_lightness;
         alpha1_ff  <= req_alpha;
      end
   end

   // Stage 2: offset term and the two component terms, all over the common divisor.
   // The offset A = 510 * L - chroma never goes negative for any input byte pair.
   logic [LTERM_W-1:0] lterm;
   logic [LTERM_W-1:0] offset;
   logic [NUM_W-1:0]   off_in, off_ff;
   logic [NUM_W-1:0]   compx_in, compx_ff;
   logic [NUM_W-1:0]   compc_in, compc_ff;
   chan_sel_type       sel_in, sel_ff;
   logic [BYTE_W-1:0]  alpha2_ff;

   always_comb begin
      lterm    = LTERM_W'({9'd0, light_ff} * 17'd510);
      offset   = lterm - LTERM_W'(chroma_ff);
      off_in   = NUM_W'(offset) * NUM_W'(SECT_LEN);
      compx_in = NUM_W'({chroma_ff, 1'b0}) * NUM_W'(tri_ff);
      compc_in = NUM_W'({chroma_ff, 1'b0}) * NUM_W'(SECT_LEN);
      sel_in   = sector_sel(sector1_ff);
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         off_ff    <= off_in;
         compx_ff  <= compx_in;
         compc_ff  <= compc_in;
         sel_ff    <= sel_in;
         alpha2_ff <= alpha1_ff;
      end
   end

   // Stage 3: per-channel numerator, the offset plus the component placed on that channel.
   function automatic logic [NUM_W-1:0] comp_pick(input sel_type sel,
                                                  input logic [NUM_W-1:0] x,
                                                  input logic [NUM_W-1:0] c);
      logic [NUM_W-1:0] pick;
      case (sel)
         SEL_X:   pick = x;
         SEL_C:   pick = c;
         default: pick = '0;
      endcase
      return pick;
   endfunction

   logic [NUM_W-1:0]  num_red_in, num_red_ff;
   logic [NUM_W-1:0]  num_green_in, num_green_ff;
   logic [NUM_W-1:0]  num_blue_in, num_blue_ff;
   logic [BYTE_W-1:0] alpha3_ff;

   always_comb begin
      num_red_in   = off_ff + comp_pick(sel_ff.red, compx_ff, compc_ff);
      num_green_in = off_ff + comp_pick(sel_ff.green, compx_ff, compc_ff);
      num_blue_in  = off_ff + comp_pick(sel_ff.blue, compx_ff, compc_ff);
   end

   always_ff @(posedge clock) begin
      if (advance[2]) begin
         num_red_ff   <= num_red_in;
         num_green_ff <= num_green_in;
         num_blue_ff  <= num_blue_in;
         alpha3_ff    <= alpha2_ff;
      end
   end

   // Stage 4: multiply by the rounded-up reciprocal of the divisor. The reciprocal carries
   // enough bits that the top of the product is the exact truncated quotient.
   logic [PROD_W-1:0]  prod_red_in, prod_red_ff;
   logic [PROD_W-1:0]  prod_green_in, prod_green_ff;
   logic [PROD_W-1:0]  prod_blue_in, prod_blue_ff;
   logic [BYTE_W-1:0]  alpha4_ff;

   always_comb begin
      prod_red_in   = PROD_W'(num_red_ff) * PROD_W'(RECIP_W'(RECIP));
      prod_green_in = PROD_W'(num_green_ff) * PROD_W'(RECIP_W'(RECIP));
      prod_blue_in  = PROD_W'(num_blue_ff) * PROD_W'(RECIP_W'(RECIP));
   end

   always_ff @(posedge clock) begin
      if (advance[3]) begin
         prod_red_ff   <= prod_red_in;
         prod_green_ff <= prod_green_in;
         prod_blue_ff  <= prod_blue_in;
         alpha4_ff     <= alpha3_ff;
      end
   end

   // Stage 5: take the quotient and saturate it to a byte. This is the output register.
   function automatic logic [BYTE_W-1:0] clamp_byte(input logic [PROD_W-1:0] prod);
      logic [QUOT_W-1:0] quot;
      quot = prod[PROD_W-1:RECIP_SHIFT];
      if (quot > QUOT_W'(255)) begin
         return '1;
      end
      return quot[BYTE_W-1:0];
   endfunction

   logic [BYTE_W-1:0] red_ff, green_ff, blue_ff, opacity_ff;

   always_ff @(posedge clock) begin
      if (advance[4]) begin
         red_ff     <= clamp_byte(prod_red_ff);
         green_ff   <= clamp_byte(prod_green_ff);
         blue_ff    <= clamp_byte(prod_blue_ff);
         opacity_ff <= alpha4_ff;
      end
   end

   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_opacity = opacity_ff;

endmodule

/* design/hrc_checker.sv */
module hrc_checker import hrc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [HUE_W-1:0]  req_hue,
   input logic [BYTE_W-1:0] req_saturation,
   input logic [BYTE_W-1:0] req_lightness,
   input logic [BYTE_W-1:0] req_alpha,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_red,
   input logic [BYTE_W-1:0] rsp_green,
   input logic [BYTE_W-1:0] rsp_blue,
   input logic [BYTE_W-1:0] rsp_opacity
);

   // Follows each accepted transaction for as long as the output side never stalls,
   // in which case it must show up on the rsp channel when its bit reaches the end of track_ff.
   logic [4:0]        track_ff;
   logic [4:0]        grey_ff;
   logic [BYTE_W-1:0] alpha_ff [5];
   logic              grey_in;

   assign grey_in = (req_saturation == '0) ||
                    (32'(req_hue) >= 32'(NUM_SECTORS * SECT_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= '0;
      end else begin
         track_ff[0] <= req_valid && req_ready;
         for (int k = 1; k < 5; k++) begin
            track_ff[k] <= track_ff[k-1] && rsp_ready;
         end
      end
   end

   always_ff @(posedge clock) begin
      grey_ff[0]  <= grey_in;
      alpha_ff[0] <= req_alpha;
      for (int k = 1; k < 5; k++) begin
         grey_ff[k]  <= grey_ff[k-1];
         alpha_ff[k] <= alpha_ff[k-1];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) &&
                                  $stable(rsp_blue) && $stable(rsp_opacity))
      else $error("stalled transaction changed on the rsp channel");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while the rsp channel is ready");

   a_latency_alpha: assert property (@(posedge clock) disable iff (reset)
      track_ff[4] |-> rsp_valid && rsp_opacity == alpha_ff[4])
      else $error("transaction late or alpha not passed through");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      track_ff[4] && grey_ff[4] |-> rsp_red == rsp_green && rsp_green == rsp_blue)
      else $error("grey pixel produced unequal channels");

endmodule

bind hsl_to_rgb_converter hrc_checker u_hrc_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps

// Pixel-level testbench for the HSL to RGB converter.
// Every accepted request is turned into an expected RGBA pixel by a local
// fixed-point model of the conversion. Every accepted response is compared
// against the oldest expected pixel. The request side sends in bursts with
// random gaps. The response side stalls on its own changing pattern.
module testbench import hrc_pkg::*; ();

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] opacity;
   } rgba_pixel_type;

   // Clock, reset and block inputs all start at known values.
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [HUE_W-1:0]  req_hue        = '0;
   logic [BYTE_W-1:0] req_saturation = '0;
   logic [BYTE_W-1:0] req_lightness  = '0;
   logic [BYTE_W-1:0] req_alpha      = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [BYTE_W-1:0] rsp_red;
   logic [BYTE_W-1:0] rsp_green;
   logic [BYTE_W-1:0] rsp_blue;
   logic [BYTE_W-1:0] rsp_opacity;

   // Pixels that the converter still owes us, oldest first.
   rgba_pixel_type expected_pixels[$];
   int             mismatches = 0;

   // Number of transactions left in the current request burst.
   int burst_left = 1;

   hsl_to_rgb_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_opacity    (rsp_opacity)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scales one channel numerator (component plus offset, over the common
   // denominator) to a byte. The value is truncated and then clamped at 255.
   function automatic logic [BYTE_W-1:0] channel_byte(input longint unsigned comp,
                                                     input longint unsigned offset,
                                                     input longint unsigned denom);
      longint unsigned value;
      value = ((comp + offset) * 64'd255) / denom;
      return (value > 64'd255) ? 8'd255 : value[BYTE_W-1:0];
   endfunction

   // Computes the RGBA pixel for one HSL pixel. All intermediate terms are
   // kept exact over the denominator 2 * 65025 * sector length, so nothing
   // is rounded before the final truncation.
   function automatic rgba_pixel_type hsl_to_rgba(input logic [HUE_W-1:0]  hue,
                                                  input logic [BYTE_W-1:0] sat,
                                                  input logic [BYTE_W-1:0] light,
                                                  input logic [BYTE_W-1:0] alpha);
      longint unsigned sect_len, denom, twice_l, light_dist, chroma;
      longint unsigned hue_mod, hue_dist, ramp;
      longint unsigned c_num, x_num, l_part, c_half, m_num;
      longint unsigned red_num, green_num, blue_num, sector;
      rgba_pixel_type  pixel;

      sect_len = SECT_LEN;
      denom    = 64'd2 * 64'd65025 * sect_len;

      // Chroma times 65025: (255 - |2l - 255|) * s.
      twice_l    = 64'd2 * light;
      light_dist = (twice_l >= 64'd255) ? twice_l - 64'd255 : 64'd255 - twice_l;
      chroma     = (64'd255 - light_dist) * sat;

      // Triangle wave of the hue position within a pair of sectors.
      hue_mod  = hue % (64'd2 * sect_len);
      hue_dist = (hue_mod >= sect_len) ? hue_mod - sect_len : sect_len - hue_mod;
      ramp     = sect_len - hue_dist;

      c_num = chroma * 64'd2 * sect_len;
      x_num = 64'd2 * chroma * ramp;

      // Lightness offset M = L - C/2, floored at zero.
      l_part = 64'd510 * sect_len * light;
      c_half = chroma * sect_len;
      m_num  = (l_part >= c_half) ? l_part - c_half : 64'd0;

      red_num   = 0;
      green_num = 0;
      blue_num  = 0;
      sector    = hue / sect_len;
      case (sector)
         0: begin
            red_num   = c_num;
            green_num = x_num;
         end
         1: begin
            red_num   = x_num;
            green_num = c_num;
         end
         2: begin
            green_num = c_num;
            blue_num  = x_num;
         end
         3: begin
            green_num = x_num;
            blue_num  = c_num;
         end
         4: begin
            red_num  = x_num;
            blue_num = c_num;
         end
         5: begin
            red_num  = c_num;
            blue_num = x_num;
         end
         default: begin
            // A hue at or beyond 360 degrees leaves only the grey offset.
         end
      endcase

      pixel.red     = channel_byte(red_num, m_num, denom);
      pixel.green   = channel_byte(green_num, m_num, denom);
      pixel.blue    = channel_byte(blue_num, m_num, denom);
      pixel.opacity = alpha;
      return pixel;
   endfunction

   // Request monitor. Signals are read at the rising edge, before the
   // block's own registers update, so this sees the values of the cycle
   // that is ending. Each accepted transaction queues its expected pixel.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_pixels.push_back(hsl_to_rgba(req_hue, req_saturation,
                                               req_lightness, req_alpha));
      end
   end

   // Response checker. Each accepted response is compared field by field
   // with the oldest expected pixel. Only the first ten problems are shown.
   always @(posedge clock) begin
      rgba_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response with nothing expected: r=%0d g=%0d b=%0d a=%0d",
                        $realtime, rsp_red, rsp_green, rsp_blue, rsp_opacity);
            end
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_red !== want.red || rsp_green !== want.green ||
                rsp_blue !== want.blue || rsp_opacity !== want.opacity) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"%0t: mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
                            " got r=%0d g=%0d b=%0d a=%0d"},
                           $realtime, want.red, want.green, want.blue, want.opacity,
                           rsp_red, rsp_green, rsp_blue, rsp_opacity);
               end
            end
         end
      end
   end

   // Response back-pressure. Every so often a new stall mode is picked:
   // always ready, mostly ready, mostly stalled, or long stall runs.
   // Ready changes only at the falling edge.
   int stall_mode     = 0;
   int mode_left      = 0;
   int stall_run_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_run_left > 0) begin
               stall_run_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) begin
                  stall_run_left = $urandom_range(1, 12);
               end
            end
         end
      endcase
   end

   // Sends one pixel. It is called at a falling edge and returns at a
   // falling edge. Valid stays high across back-to-back transactions of a
   // burst. When a burst ends, valid drops for a random gap, which may be
   // zero so that some bursts run together.
   task automatic send_pixel(input logic [HUE_W-1:0]  hue,
                             input logic [BYTE_W-1:0] sat,
                             input logic [BYTE_W-1:0] light,
                             input logic [BYTE_W-1:0] alpha);
      int gap;
      req_hue        <= hue;
      req_saturation <= sat;
      req_lightness  <= light;
      req_alpha      <= alpha;
      req_valid      <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
   endtask

   // Extreme field values: all zero, all ones, and the lightness midpoint.
   task automatic test_field_extremes();
      send_pixel(13'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(13'd0, 8'd255, 8'd127, 8'd255);
      send_pixel(13'd0, 8'd255, 8'd128, 8'd0);
      send_pixel(13'd5759, 8'd255, 8'd255, 8'd170);
      send_pixel(13'd480, 8'd255, 8'd0, 8'd85);
   endtask

   // The first hue of every 60-degree sector at full saturation and mid lightness, and the
   // last at saturation 200 and lightness 100, so that each sector's channel placement shows.
   task automatic test_sector_edges();
      for (int k = 0; k < NUM_SECTORS; k++) begin
         send_pixel(HUE_W'(k * SECT_LEN), 8'd255, 8'd128, 8'(k));
         send_pixel(HUE_W'(k * SECT_LEN + SECT_LEN - 1), 8'd200, 8'd100, 8'(255 - k));
      end
   endtask

   // Hues at or beyond 360 degrees give grey, and so does zero saturation.
   task automatic test_grey_pixels();
      send_pixel(13'd5760, 8'd255, 8'd100, 8'd1);
      send_pixel(13'd8191, 8'd200, 8'd200, 8'd254);
      send_pixel(13'd6000, 8'd0, 8'd255, 8'd128);
      send_pixel(13'd1234, 8'd0, 8'd77, 8'd64);
      send_pixel(13'd2000, 8'd0, 8'd255, 8'd32);
   endtask

   // Mostly in-range hues with random content. Some hues are placed near
   // sector boundaries, some in the grey range, and some anywhere in the
   // field. Saturation and lightness hit their extremes now and then.
   task automatic test_random_pixels(input int count);
      logic [HUE_W-1:0]  hue;
      logic [BYTE_W-1:0] sat;
      logic [BYTE_W-1:0] light;
      int                pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            hue = HUE_W'($urandom_range(0, NUM_SECTORS * SECT_LEN - 1));
         end else if (pick == 7) begin
            hue = HUE_W'($urandom_range(0, NUM_SECTORS) * SECT_LEN + $urandom_range(0, 4) - 2);
         end else if (pick == 8) begin
            hue = HUE_W'($urandom_range(NUM_SECTORS * SECT_LEN, (1 << HUE_W) - 1));
         end else begin
            hue = HUE_W'($urandom);
         end
         if ($urandom_range(0, 7) == 0) begin
            sat = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else begin
            sat = BYTE_W'($urandom);
         end
         if ($urandom_range(0, 7) == 0) begin
            light = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else begin
            light = BYTE_W'($urandom);
         end
         send_pixel(hue, sat, light, BYTE_W'($urandom));
      end
   endtask

   initial begin
      // Reset is released at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_field_extremes();
      test_sector_edges();
      test_grey_pixels();
      test_random_pixels(2000);
      req_valid <= 1'b0;

      // Wait for every expected pixel, then keep watching to catch any
      // stray response. The timeout process bounds this wait.
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("[hsl_to_rgb_converter] OK");
      end else begin
         $display("[hsl_to_rgb_converter] ERROR");
      end
      $finish;
   end

   // Watchdog. A correct run takes well under a tenth of this time.
   initial begin
      #5_000_000;
      $display("[hsl_to_rgb_converter] ERROR");
      $finish;
   end

endmodule
